// ===== rtl/mvt_pkg.sv =====
package mvt_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned REG_W    = 64;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned NUM_ROWS = 4;

    typedef enum logic {
        ACT_VECTOR = 1'b0,
        ACT_POINT  = 1'b1
    } t_action;

    typedef logic signed [WORD_W-1:0] t_word;

    // flags carried through the pipeline
    typedef struct packed {
        logic sat;
        logic dz;
    } t_flags;

    // saturate a wide signed value to the 32-bit range
    function automatic t_word clip_word(input logic signed [WORD_W+7:0] v, output logic sat);
        logic signed [WORD_W+7:0] hi;
        logic signed [WORD_W+7:0] lo;
        hi = (WORD_W+8)'(signed'({1'b0, {(WORD_W-1){1'b1}}}));
        lo = -hi - (WORD_W+8)'(1);
        sat = 1'b0;
        if (v > hi) begin
            sat = 1'b1;
            return t_word'({1'b0, {(WORD_W-1){1'b1}}});
        end
        if (v < lo) begin
            sat = 1'b1;
            return t_word'({1'b1, {(WORD_W-1){1'b0}}});
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/mvt_if.sv =====
interface mvt_in_if;
    import mvt_pkg::*;
    logic    valid;
    logic    ready;
    t_action action;
    t_word   in_x;
    t_word   in_y;
    t_word   in_z;
    t_word   in_w;
    modport source (output valid, action, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, action, in_x, in_y, in_z, in_w, output ready);
endinterface

interface mvt_out_if;
    import mvt_pkg::*;
    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;
    t_word out_z;
    t_word out_w;
    logic  sum_saturated;
    logic  divide_by_zero;
    modport source (output valid, out_x, out_y, out_z, out_w, sum_saturated, divide_by_zero,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, sum_saturated, divide_by_zero,
                    output ready);
endinterface

interface mvt_cfg_if;
    import mvt_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [REG_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mvt_div.sv =====
// pipelined restoring divider: one quotient bit per stage, stalls with en
module mvt_div
    import mvt_pkg::*;
#(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 31,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];
    logic             r_vld [NUM_W+1];

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
        r_vld[0] = i_valid;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] n_trial;
        logic [DEN_W+1:0] n_diff;
        assign n_trial = {r_rem[k][DEN_W-1:0], r_num[k][NUM_W-1]};
        assign n_diff  = {1'b0, n_trial} - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_diff[DEN_W+1] ? n_trial : n_diff[DEN_W:0];
                r_num[k+1] <= {r_num[k][NUM_W-2:0], ~n_diff[DEN_W+1]};
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule

// ===== rtl/mvt_dot.sv =====
// one matrix row times the vector: product stage, then sum and saturate stage
module mvt_dot
    import mvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [REG_W-1:0] i_row01,
    input  logic [REG_W-1:0] i_row23,
    input  t_word           i_v [NUM_ROWS],
    output t_word           o_sum,
    output logic            o_sat
);

    localparam int unsigned PROD_W = 2 * WORD_W;
    // four shifted products summed exactly need two bits over one shifted product
    localparam int unsigned SUM_W  = PROD_W - FRAC_BITS + 2;

    logic signed [PROD_W-1:0] r_prod [NUM_ROWS];
    t_word                    n_elem [NUM_ROWS];
    logic signed [SUM_W-1:0]  n_acc;
    t_word                    n_sum;
    logic                     n_sat;

    assign n_elem[0] = i_row01[WORD_W-1:0];
    assign n_elem[1] = i_row01[REG_W-1:WORD_W];
    assign n_elem[2] = i_row23[WORD_W-1:0];
    assign n_elem[3] = i_row23[REG_W-1:WORD_W];

    // products, one multiplier per column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                r_prod[j] <= n_elem[j] * i_v[j];
            end
        end
    end

    // floor shift each product, then sum exactly and saturate
    always_comb begin
        n_acc = '0;
        for (int j = 0; j < NUM_ROWS; j++) begin
            n_acc = n_acc + SUM_W'(r_prod[j] >>> FRAC_BITS);
        end
        n_sat = (n_acc[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){n_acc[SUM_W-1]}});
        if (n_sat) begin
            n_sum = n_acc[SUM_W-1] ? t_word'({1'b1, {(WORD_W-1){1'b0}}})
                                   : t_word'({1'b0, {(WORD_W-1){1'b1}}});
        end else begin
            n_sum = n_acc[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum <= n_sum;
            o_sat <= n_sat;
        end
    end

endmodule

// ===== rtl/matrix_vector_transform.sv =====
// stages: input register, product, sum, divider setup, divider stages, output register
// throughput: one word per cycle; the divider is fully pipelined, one quotient bit a stage
// a stall on the output freezes the whole pipeline, words are held, none lost
// reset: synchronous active low; clears valid bits and loads the identity matrix
module matrix_vector_transform
    import mvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvt_cfg_if.sink   cfg,
    mvt_in_if.sink    in_ch,
    mvt_out_if.source out_ch
);

    localparam int unsigned NUM_W   = WORD_W + FRAC_BITS;
    localparam int unsigned DEN_W   = WORD_W;
    localparam int unsigned TAG_W   = 2 + 3 * WORD_W + 3 + 3;
    localparam int unsigned DIV_LAT = NUM_W;

    logic [REG_W-1:0] r_mat [NUM_REGS];
    logic             en;
    logic             r_out_vld;

    // config writes; out of range index ignored
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= REG_W'(64'd1 << FRAC_BITS);
            r_mat[1] <= '0;
            r_mat[2] <= REG_W'(64'd1 << (FRAC_BITS + WORD_W));
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= REG_W'(64'd1 << FRAC_BITS);
            r_mat[6] <= '0;
            r_mat[7] <= REG_W'(64'd1 << (FRAC_BITS + WORD_W));
        end else if (cfg.valid && cfg.index < IDX_W'(NUM_REGS)) begin
            r_mat[cfg.index[2:0]] <= cfg.data;
        end
    end

    // whole pipeline advances unless the output word is stuck
    assign en          = !r_out_vld || out_ch.ready;
    assign in_ch.ready = en;

    // stage 0: input register with w forced in point mode
    logic  r_v0;
    logic  r_pt0;
    t_word r_vec [NUM_ROWS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= in_ch.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt0    <= (in_ch.action == ACT_POINT);
            r_vec[0] <= in_ch.in_x;
            r_vec[1] <= in_ch.in_y;
            r_vec[2] <= in_ch.in_z;
            r_vec[3] <= (in_ch.action == ACT_POINT) ? t_word'(1 << FRAC_BITS) : in_ch.in_w;
        end
    end

    // stages 1 and 2: four dot products
    t_word r_sum [NUM_ROWS];
    logic  sat_row [NUM_ROWS];
    for (genvar i = 0; i < NUM_ROWS; i++) begin : g_row
        mvt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_row01 (r_mat[2*i]),
            .i_row23 (r_mat[2*i+1]),
            .i_v     (r_vec),
            .o_sum   (r_sum[i]),
            .o_sat   (sat_row[i])
        );
    end
    logic [1:0] r_v12;
    logic [1:0] r_pt12;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12 <= '0;
        end else if (en) begin
            r_v12 <= {r_v12[0], r_v0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt12 <= {r_pt12[0], r_pt0};
        end
    end

    // stage 3: magnitudes and signs for the dividers
    logic             r_v3;
    logic             r_pt3;
    logic             r_sat3;
    t_word            r_s3 [NUM_ROWS];
    logic [NUM_W-1:0] r_mag [3];
    logic [DEN_W-1:0] r_den;
    logic [2:0]       r_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v12[1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt3  <= r_pt12[1];
            r_sat3 <= sat_row[0] | sat_row[1] | sat_row[2] | sat_row[3];
            r_den  <= r_sum[3][WORD_W-1] ? DEN_W'(-r_sum[3]) : DEN_W'(r_sum[3]);
            for (int i = 0; i < NUM_ROWS; i++) begin
                r_s3[i] <= r_sum[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_sum[i][WORD_W-1] ^ r_sum[3][WORD_W-1];
                r_mag[i] <= {(r_sum[i][WORD_W-1] ? WORD_W'(-r_sum[i]) : WORD_W'(r_sum[i])),
                             {FRAC_BITS{1'b0}}};
            end
        end
    end

    // divider pipeline, sums and flags ride along as a tag
    logic [TAG_W-1:0] tag_in;
    logic [TAG_W-1:0] tag_out [3];
    logic [NUM_W-1:0] quo [3];
    logic             dv_vld [3];
    assign tag_in = {r_pt3, r_sat3, r_s3[0], r_s3[1], r_s3[2], r_neg,
                     r_s3[2] == '0, r_s3[1] == '0, r_s3[0] == '0};
    for (genvar i = 0; i < 3; i++) begin : g_div
        mvt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_v3),
            .i_num   (r_mag[i]),
            .i_den   (r_den),
            .i_tag   (tag_in),
            .o_valid (dv_vld[i]),
            .o_quo   (quo[i]),
            .o_tag   (tag_out[i])
        );
    end

    // w rides in a plain delay line
    t_word r_wd [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wd[0] <= r_s3[3];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_wd[k] <= r_wd[k-1];
            end
        end
    end

    // final stage: sign, saturation, zero w
    logic                    t_pt;
    logic                    t_sat;
    t_word                   t_s [3];
    logic [2:0]              t_neg;
    logic [2:0]              t_zero;
    logic                    w_zero;
    t_word                   n_res [3];
    logic [2:0]              n_qs;
    logic signed [WORD_W+7:0] n_sq;
    logic [NUM_W:0]          n_sgn;
    assign {t_pt, t_sat, t_s[0], t_s[1], t_s[2], t_neg, t_zero} = tag_out[0];
    assign w_zero = (r_wd[DIV_LAT-1] == '0);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sgn = t_neg[i] ? -{1'b0, quo[i]} : {1'b0, quo[i]};
            if (n_sgn[NUM_W:WORD_W+7] != {(NUM_W-WORD_W-6){n_sgn[WORD_W+7]}}) begin
                n_sq = n_sgn[NUM_W] ? {1'b1, {(WORD_W+7){1'b0}}} : {1'b0, {(WORD_W+7){1'b1}}};
            end else begin
                n_sq = n_sgn[WORD_W+7:0];
            end
            n_res[i] = clip_word(n_sq, n_qs[i]);
            if (!t_pt) begin
                n_res[i] = t_s[i];
                n_qs[i]  = 1'b0;
            end else if (w_zero) begin
                n_qs[i]  = 1'b0;
                n_res[i] = t_zero[i] ? t_word'(0) :
                           (t_s[i][WORD_W-1] ? t_word'({1'b1, {(WORD_W-1){1'b0}}})
                                             : t_word'({1'b0, {(WORD_W-1){1'b1}}}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld[0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            out_ch.out_x          <= n_res[0];
            out_ch.out_y          <= n_res[1];
            out_ch.out_z          <= n_res[2];
            out_ch.out_w          <= r_wd[DIV_LAT-1];
            out_ch.sum_saturated  <= t_sat | (|n_qs);
            out_ch.divide_by_zero <= t_pt & w_zero;
        end
    end
    assign out_ch.valid = r_out_vld;

    // the three dividers stay in lockstep
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld[0] == dv_vld[1] && dv_vld[1] == dv_vld[2])
        else $error("divider lanes out of step");
    // a held output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !out_ch.ready |=> r_out_vld && $stable(out_ch.out_x))
        else $error("output word lost under stall");
    // divide by zero flagged only with a zero w
    a_dz_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.divide_by_zero |-> out_ch.out_w == '0)
        else $error("divide by zero flag with nonzero w");

endmodule

// ===== test/matrix_vector_transform_checker.sv =====
module matrix_vector_transform_checker
    import mvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvt_cfg_if.sink   cfg,
    mvt_in_if.sink    in_ch,
    mvt_out_if.sink   out_ch,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        t_word w;
        logic  sat;
        logic  dz;
    } t_result;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    logic [REG_W-1:0] matrix_regs [NUM_REGS];
    t_result          expected_words [$];
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    // matrix element from the packed register pair
    function automatic logic signed [63:0] element(int row, int col);
        logic [REG_W-1:0] r;
        r = matrix_regs[row * 2 + col / 2];
        return (col % 2) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
    endfunction

    // saturate to word range, marking the flag
    function automatic logic signed [63:0] clamp_word(logic signed [63:0] v, ref logic sat);
        if (v > WORD_MAX) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // transform one vector, with optional perspective divide
    function automatic t_result transform(t_action act, t_word ix, t_word iy, t_word iz,
                                          t_word iw);
        logic signed [63:0] vec [4];
        logic signed [63:0] sums [4];
        logic signed [63:0] res [3];
        logic signed [63:0] acc;
        logic signed [63:0] num;
        logic               sat;
        logic               dz;
        t_result            r;
        sat = 1'b0;
        dz  = 1'b0;
        vec[0] = 64'(ix);
        vec[1] = 64'(iy);
        vec[2] = 64'(iz);
        vec[3] = (act == ACT_POINT) ? (64'sd1 <<< FRAC_BITS) : 64'(iw);
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            // arithmetic shift floors toward minus infinity
            for (int j = 0; j < 4; j++)
                acc += (element(i, j) * vec[j]) >>> FRAC_BITS;
            sums[i] = clamp_word(acc, sat);
        end
        for (int i = 0; i < 3; i++) begin
            if (act == ACT_VECTOR) begin
                res[i] = sums[i];
            end else if (sums[3] == 0) begin
                dz = 1'b1;
                res[i] = (sums[i] > 0) ? WORD_MAX : ((sums[i] < 0) ? WORD_MIN : 64'sd0);
            end else begin
                num = sums[i] * (64'sd1 <<< FRAC_BITS);
                res[i] = clamp_word(num / sums[3], sat);
            end
        end
        r.x   = t_word'(res[0]);
        r.y   = t_word'(res[1]);
        r.z   = t_word'(res[2]);
        r.w   = t_word'(sums[3]);
        r.sat = sat;
        r.dz  = dz;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // track config, predict inputs, compare output words
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            matrix_regs[0] = REG_W'(1) << FRAC_BITS;
            matrix_regs[1] = '0;
            matrix_regs[2] = REG_W'(1) << (FRAC_BITS + 32);
            matrix_regs[3] = '0;
            matrix_regs[4] = '0;
            matrix_regs[5] = REG_W'(1) << FRAC_BITS;
            matrix_regs[6] = '0;
            matrix_regs[7] = REG_W'(1) << (FRAC_BITS + 32);
            expected_words.delete();
            fail_count = fail_count;
        end else begin
            if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
                matrix_regs[cfg.index] = cfg.data;
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(transform(in_ch.action, in_ch.in_x, in_ch.in_y,
                                                   in_ch.in_z, in_ch.in_w));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", out_ch.out_x, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (out_ch.out_x !== want.x) report_mismatch("out_x", out_ch.out_x, want.x);
                    if (out_ch.out_y !== want.y) report_mismatch("out_y", out_ch.out_y, want.y);
                    if (out_ch.out_z !== want.z) report_mismatch("out_z", out_ch.out_z, want.z);
                    if (out_ch.out_w !== want.w) report_mismatch("out_w", out_ch.out_w, want.w);
                    if (out_ch.sum_saturated !== want.sat)
                        report_mismatch("sum_saturated", 32'(out_ch.sum_saturated), 32'(want.sat));
                    if (out_ch.divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", 32'(out_ch.divide_by_zero),
                                        32'(want.dz));
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// ===== test/matrix_vector_transform_tb.sv =====
module matrix_vector_transform_tb;
    import mvt_pkg::*;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int          LATENCY     = 3 + 32 + FRAC_BITS + 2;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_WORDS = 480;
    localparam logic [31:0] ONE_Q       = 32'(1) << FRAC_BITS;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    mvt_cfg_if cfg();
    mvt_in_if  in_ch();
    mvt_out_if out_ch();

    matrix_vector_transform #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    matrix_vector_transform_checker #(.FRAC_BITS(FRAC_BITS)) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cfg         (cfg.sink),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // cycle limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix_vector_transform_tb failed");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // random word with a bias toward edge values
    function automatic t_word pick_value();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return ONE_Q;
            3: return 32'($urandom_range(0, 8)) << FRAC_BITS;
            4: return -(32'($urandom_range(0, 8)) << FRAC_BITS);
            5: return 0;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(int idx, logic [REG_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= IDX_W'(idx);
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(t_action act, t_word x, t_word y, t_word z, t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.in_x   <= x;
        in_ch.in_y   <= y;
        in_ch.in_z   <= z;
        in_ch.in_w   <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // wait for the pipe to drain before touching the matrix
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_matrix(int kind);
        for (int i = 0; i < NUM_REGS; i++) begin
            case (kind)
                0: write_reg(i, {$urandom(), $urandom()});
                1: write_reg(i, {32'h7fffffff, 32'h7fffffff});
                2: write_reg(i, {32'h80000000, 32'h80000000});
                3: write_reg(i, '0);
                default: write_reg(i, {32'($urandom_range(0, 3)) << FRAC_BITS,
                                       32'($urandom_range(0, 3)) << (FRAC_BITS - 1)});
            endcase
        end
    endtask

    task automatic random_words(int count);
        for (int n = 0; n < count; n++)
            send_word(t_action'($urandom_range(1)), pick_value(), pick_value(), pick_value(),
                      pick_value());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_VECTOR;
        in_ch.in_x    = '0;
        in_ch.in_y    = '0;
        in_ch.in_z    = '0;
        in_ch.in_w    = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity matrix, field extremes, both actions, zero w
        send_word(ACT_VECTOR, 32'h7fffffff, 32'h80000000, 0, ONE_Q);
        send_word(ACT_VECTOR, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000);
        send_word(ACT_POINT, ONE_Q, -ONE_Q, 0, 32'h7fffffff);
        send_word(ACT_POINT, 32'h7fffffff, 32'h80000000, 32'h00000001, 0);
        drain();
        // w row all zero gives a zero divisor
        write_reg(6, '0);
        write_reg(7, '0);
        send_word(ACT_POINT, ONE_Q, -ONE_Q, 0, ONE_Q);
        send_word(ACT_POINT, 0, 0, 0, 0);
        drain();
        // small w forces quotient saturation; full scale forces sum saturation
        write_reg(7, {32'h00000001, 32'h0});
        send_word(ACT_POINT, 32'h7fffffff, 32'h80000000, ONE_Q, 0);
        drain();
        load_matrix(1);
        send_word(ACT_VECTOR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_word(ACT_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(ACT_POINT, 32'h80000000, 32'h7fffffff, 0, 0);
        drain();
        load_matrix(2);
        send_word(ACT_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(ACT_VECTOR, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h80000000);
        send_word(ACT_POINT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        drain();
        load_matrix(3);
        send_word(ACT_POINT, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        drain();

        // random phases with changing matrices and idle patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : ((phase == 1) ? 70 : 0);
            recv_idle_pct = (phase == 0) ? 70 : ((phase == 1) ? 27 : 0);
            for (int part = 0; part < 4; part++) begin
                load_matrix((part == 3) ? 0 : ((part % 2) ? 4 : 0));
                random_words(PHASE_WORDS / 4);
                drain();
            end
        end

        if (fail_count == 0) begin
            $display("matrix_vector_transform_tb passed");
        end else begin
            $display("matrix_vector_transform_tb failed");
        end
        $finish;
    end

endmodule
